// ===== hdl/cre_pkg.sv =====
// Shared types and constants for the CIGAR reference window extractor.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package cre_pkg;

   localparam int LEN_W = 28;
   localparam int OUT_LEN_W = 31;
   localparam int POS_W = 32;
   localparam int CODE_W = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam int OBUF_DEPTH = 2;
   localparam int OPTR_W = 1;
   localparam int OCNT_W = 2;

   // Operation characters that consume reference.
   localparam logic [CODE_W-1:0] CODE_M = 8'h4D;
   localparam logic [CODE_W-1:0] CODE_EQ = 8'h3D;
   localparam logic [CODE_W-1:0] CODE_X = 8'h58;
   localparam logic [CODE_W-1:0] CODE_D = 8'h44;

   // Configuration register indexes.
   localparam logic CSR_WINDOW_START = 1'b0;
   localparam logic CSR_WINDOW_LENGTH = 1'b1;

   localparam logic [OUT_LEN_W-1:0] LEN_MAX = {OUT_LEN_W{1'b1}};

   typedef struct packed {
      logic [LEN_W-1:0] op_length;
      logic [CODE_W-1:0] op_code;
      logic final_op;
   } req_type;

   typedef struct packed {
      logic [OUT_LEN_W-1:0] out_length;
      logic [CODE_W-1:0] out_code;
      logic out_last;
      logic out_empty;
   } rsp_type;

   // One classified item on its way from the front to the merge stage.
   typedef struct packed {
      logic keep;
      logic [LEN_W-1:0] len;
      logic [CODE_W-1:0] code;
      logic fin;
   } piece_type;

endpackage

`default_nettype wire

// ===== hdl/cre_front.sv =====
// Front part: holds the window registers and the reference position, trims
// each item against the window and classifies it. Depends on cre_pkg.
`default_nettype none

module cre_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic csr_index,
   input wire logic [cre_pkg::OUT_LEN_W-1:0] csr_wdata,
   input wire logic accept,
   input wire cre_pkg::req_type req,
   output logic push,
   output cre_pkg::piece_type piece
);
   import cre_pkg::*;

   logic [OUT_LEN_W-1:0] start_ff, start_in;
   logic [OUT_LEN_W-1:0] wlen_ff, wlen_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [OUT_LEN_W-1:0] taken_ff, taken_in;

   logic active, is_ref, pre_window, pos_lt;
   logic [POS_W:0] endp;
   logic [POS_W:0] endp_off;
   logic [OUT_LEN_W-1:0] room;
   logic [LEN_W-1:0] use0, use_len;
   logic [POS_W-1:0] pos_base;

   always_comb begin
      active = taken_ff < wlen_ff;
      is_ref = (req.op_code == CODE_M) || (req.op_code == CODE_EQ) ||
               (req.op_code == CODE_X) || (req.op_code == CODE_D);
      endp = {1'b0, pos_ff} + {{(POS_W-LEN_W+1){1'b0}}, req.op_length};
      pre_window = endp <= {2'b00, start_ff};
      pos_lt = pos_ff < {1'b0, start_ff};
      endp_off = endp - {2'b00, start_ff};
      room = wlen_ff - taken_ff;
      // An op that straddles the window start keeps only the part past it.
      use0 = pos_lt ? endp_off[LEN_W-1:0] : req.op_length;
      use_len = ({{(OUT_LEN_W-LEN_W){1'b0}}, use0} > room) ? room[LEN_W-1:0] : use0;
      pos_base = pos_lt ? {1'b0, start_ff} : pos_ff;

      piece.code = req.op_code;
      piece.fin = req.final_op;
      piece.len = is_ref ? use_len : req.op_length;
      piece.keep = active && (is_ref ? !pre_window : !pos_lt) && (piece.len != '0);
      push = accept && (piece.keep || req.final_op);

      pos_in = pos_ff;
      taken_in = taken_ff;
      if (accept) begin
         if (active && is_ref) begin
            if (pre_window) begin
               pos_in = endp[POS_W-1:0];
            end else begin
               pos_in = pos_base + {{(POS_W-LEN_W){1'b0}}, use_len};
               taken_in = taken_ff + {{(OUT_LEN_W-LEN_W){1'b0}}, use_len};
            end
         end
         if (req.final_op) begin
            pos_in = '0;
            taken_in = '0;
         end
      end

      start_in = start_ff;
      wlen_in = wlen_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_START: start_in = csr_wdata;
            CSR_WINDOW_LENGTH: wlen_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         wlen_ff <= '0;
         pos_ff <= '0;
         taken_ff <= '0;
      end else begin
         start_ff <= start_in;
         wlen_ff <= wlen_in;
         pos_ff <= pos_in;
         taken_ff <= taken_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cre_queue.sv =====
// Short queue of classified items between the front and the merge stage.
// Depends on cre_pkg.
`default_nettype none

module cre_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire cre_pkg::piece_type push_data,
   input wire logic pop,
   output logic full,
   output logic not_empty,
   output cre_pkg::piece_type head
);
   import cre_pkg::*;

   piece_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      full = count_ff == QCNT_W'(QUEUE_DEPTH);
      not_empty = count_ff != '0;
      head = entry_ff[rd_ff];
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cre_back.sv =====
// Back part: merges adjacent kept pieces of one code, flushes on the final
// item and buffers results for the receiver. Depends on cre_pkg.
`default_nettype none

module cre_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic head_valid,
   input wire cre_pkg::piece_type head,
   output logic pop,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output cre_pkg::rsp_type rsp_payload
);
   import cre_pkg::*;

   logic pv_ff, pv_in;
   logic [OUT_LEN_W-1:0] plen_ff, plen_in;
   logic [CODE_W-1:0] pcode_ff, pcode_in;
   logic half_ff, half_in;

   rsp_type obuf_ff [OBUF_DEPTH];
   logic [OPTR_W-1:0] owr_ff, owr_in, ord_ff, ord_in;
   logic [OCNT_W-1:0] ocnt_ff, ocnt_in;

   logic work, keep_eff, same, replace, emit, opop;
   logic [OUT_LEN_W:0] sum;
   rsp_type result;

   always_comb begin
      work = head_valid && (ocnt_ff != OCNT_W'(OBUF_DEPTH));
      // The keep part of an item is applied only once, even when its two
      // results leave one after the other.
      keep_eff = head.keep && !half_ff;
      same = pv_ff && (pcode_ff == head.code);
      replace = keep_eff && pv_ff && !same;
      sum = {1'b0, plen_ff} + {{(OUT_LEN_W-LEN_W+1){1'b0}}, head.len};

      pv_in = pv_ff;
      plen_in = plen_ff;
      pcode_in = pcode_ff;
      half_in = half_ff;
      pop = 1'b0;
      emit = 1'b0;
      result = '0;

      if (work) begin
         if (replace) begin
            emit = 1'b1;
            result.out_length = plen_ff;
            result.out_code = pcode_ff;
         end
         if (keep_eff) begin
            if (same) begin
               plen_in = sum[OUT_LEN_W] ? LEN_MAX : sum[OUT_LEN_W-1:0];
            end else begin
               pv_in = 1'b1;
               pcode_in = head.code;
               plen_in = {{(OUT_LEN_W-LEN_W){1'b0}}, head.len};
            end
         end
         if (replace && head.fin) begin
            // The flush follows from the updated pending op, once the buffer has room.
            half_in = 1'b1;
         end else begin
            pop = 1'b1;
            half_in = 1'b0;
            if (head.fin) begin
               emit = 1'b1;
               result.out_last = 1'b1;
               result.out_empty = !pv_in;
               result.out_length = pv_in ? plen_in : '0;
               result.out_code = pv_in ? pcode_in : '0;
               pv_in = 1'b0;
               plen_in = '0;
               pcode_in = '0;
            end
         end
      end

      rsp_valid = ocnt_ff != '0;
      rsp_payload = obuf_ff[ord_ff];
      opop = rsp_valid && rsp_ready;
      owr_in = emit ? owr_ff + 1'b1 : owr_ff;
      ord_in = opop ? ord_ff + 1'b1 : ord_ff;
      ocnt_in = ocnt_ff;
      if (emit && !opop) begin
         ocnt_in = ocnt_ff + 1'b1;
      end else if (opop && !emit) begin
         ocnt_in = ocnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         obuf_ff[owr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         plen_ff <= '0;
         pcode_ff <= '0;
         half_ff <= 1'b0;
         owr_ff <= '0;
         ord_ff <= '0;
         ocnt_ff <= '0;
      end else begin
         pv_ff <= pv_in;
         plen_ff <= plen_in;
         pcode_ff <= pcode_in;
         half_ff <= half_in;
         owr_ff <= owr_in;
         ord_ff <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cigar_reference_window_extract_core.sv =====
// Top level of the CIGAR reference window extractor.
// Depends on cre_pkg, cre_front, cre_queue and cre_back.
//
// Usage: CIGAR operations enter one item at a time on the req_ channel
// (valid/ready), with final_op set on the last operation of an alignment.
// Extracted, merged operations leave on the rsp_ channel; out_last marks the
// last one of the alignment, and out_empty marks the single result given
// when nothing fell into the window. The window is set through the csr_
// write port (index 0 start, index 1 length); the user must write it only
// while the block is idle, which the block itself does not enforce.
// The front trims each item against the window in the cycle it is accepted
// and pushes kept and final items into a four-entry queue. The back merges
// pieces of the same code and writes results into a two-entry output buffer,
// one per cycle while it has room; queue and buffer are both registered.
// Throughput is one item per cycle while nothing stalls; an item that yields
// two results holds the merge stage until the buffer has taken both.
// A stalled receiver first fills the output buffer, then the queue, and only
// then drops req_ready, so the two sides stall independently.
// Synchronous reset clears the window registers, the alignment position,
// the pending op, the queue and the buffer; no result is valid after it.
`default_nettype none

module cigar_reference_window_extract_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire cre_pkg::req_type req_payload,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output cre_pkg::rsp_type rsp_payload,
   input wire logic csr_we,
   input wire logic csr_index,
   input wire logic [cre_pkg::OUT_LEN_W-1:0] csr_wdata
);
   import cre_pkg::*;

   logic accept, push, pop, q_full, q_not_empty;
   piece_type piece, head;

   // The front advances its position only when an item is really taken.
   assign req_ready = !q_full;
   assign accept = req_valid && req_ready;

   cre_front u_front (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .accept(accept),
      .req(req_payload),
      .push(push),
      .piece(piece)
   );

   cre_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(piece),
      .pop(pop),
      .full(q_full),
      .not_empty(q_not_empty),
      .head(head)
   );

   cre_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(q_not_empty),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

// ===== hdl/cre_checker.sv =====
// Port-level checks for the CIGAR reference window extractor, with the bind
// that attaches them to the top level. Depends on cre_pkg.
`default_nettype none

module cre_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire cre_pkg::rsp_type rsp_payload
);
   import cre_pkg::*;

   // A result waiting on the receiver keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // The empty marker only comes as a bare final result.
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_empty |->
         rsp_payload.out_last && (rsp_payload.out_length == '0) &&
         (rsp_payload.out_code == '0))
      else $error("malformed empty result");

   // Zero-length pieces are never kept, so a real op has a length.
   a_nonzero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.out_empty |-> rsp_payload.out_length != '0)
      else $error("kept op with zero length");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind cigar_reference_window_extract_core cre_checker u_cre_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_payload(rsp_payload)
);

`default_nettype wire
